@@ rtl/sfpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_pkg
// Types and constants shared by the framed packet receiver modules.
// ----------------------------------------------------------------------------
package sfpr_pkg;

    // Reset value of the start byte register
    localparam logic [7:0] START_BYTE_RESET = 8'h2E;
    // Checksum is the byte sum inverted
    localparam logic [7:0] CSUM_INVERT      = 8'hFF;
    // Top value of the capture counter
    localparam logic [4:0] CAPTURE_TOP      = 5'd31;

    // Frame status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Receiver phase, one-hot
    typedef enum logic [4:0] {
        PH_WAIT = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CSUM = 5'b10000
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic       ack_request;
        logic [1:0] frame_status;
        logic [7:0] expected_checksum;
        logic [7:0] received_checksum;
        logic [3:0] data_position;
        logic [7:0] data_value;
        logic [7:0] frame_length;
        logic [7:0] frame_command;
        logic       kind;
    } result_t;

endpackage

@@ rtl/sof_framed_packet_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_framed_packet_receiver
// Start-of-frame packet receiver with additive checksum check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while s_tready is high, and gives its result
// in the next cycle from a single output register. The frame state updates
// per byte, so the rate is set by that register alone: a new byte is taken
// whenever the output register is empty or being drained in the same cycle.
// Data bytes of a frame give one data transaction each (the first BUF_DEPTH
// of them); the checksum byte gives one frame transaction with status and
// acknowledge request. Other bytes give no transaction.
// ----------------------------------------------------------------------------
module sof_framed_packet_receiver
    import sfpr_pkg::*;
#(
    parameter int BUF_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: start byte
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] frame_command, [15:8] frame_length,
                                   // [23:16] data_value, [27:24] data_position,
                                   // [35:28] received_checksum,
                                   // [43:36] expected_checksum,
                                   // [45:44] frame_status, [46] ack_request,
                                   // [47] zero
    output logic        m_tuser    // [0] kind
);

    logic [7:0] start_reg;
    logic       in_fire;
    logic       res_valid;
    result_t    res;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    // Hold the start byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_BYTE_RESET;
        end else if (cfg_wr_en) begin
            start_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    sfpr_frame_fsm #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_byte (start_reg),
        .in_fire    (in_fire),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Load the output register on each input transaction, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_fire) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0,
                       out_reg.ack_request,
                       out_reg.frame_status,
                       out_reg.expected_checksum,
                       out_reg.received_checksum,
                       out_reg.data_position,
                       out_reg.data_value,
                       out_reg.frame_length,
                       out_reg.frame_command};

endmodule

@@ rtl/sfpr_frame_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_frame_fsm
// Frame parser: holds the receiver phase, header and running sum, and forms
// the result caused by the byte presented on rx_byte.
// ----------------------------------------------------------------------------
module sfpr_frame_fsm
    import sfpr_pkg::*;
#(
    parameter int BUF_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] start_byte,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [7:0] DEPTH_B = 8'(BUF_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;
    logic [4:0] count_reg, count_next;
    logic       trunc_reg, trunc_next;

    logic [7:0] expect_csum;
    logic       capture;
    logic [1:0] status;

    assign expect_csum = sum_reg ^ CSUM_INVERT;
    assign capture     = ({3'b000, count_reg} < DEPTH_B) && (count_reg < CAPTURE_TOP);
    assign status      = trunc_reg ? ST_TRUNC :
                         ((rx_byte == expect_csum) ? ST_OK : ST_BAD);

    // Next state and result for the presented byte
    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        trunc_next   = trunc_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.frame_command = command_reg;
        res.frame_length  = length_reg;
        case (phase_reg)
            PH_WAIT: begin
                if (rx_byte == start_byte) begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                command_next = rx_byte;
                sum_next     = rx_byte;
                phase_next   = PH_LEN;
            end
            PH_LEN: begin
                length_next = rx_byte;
                sum_next    = sum_reg + rx_byte;
                count_next  = '0;
                if (rx_byte == 8'd0) begin
                    phase_next = PH_CSUM;
                end else begin
                    trunc_next = (rx_byte > DEPTH_B);
                    left_next  = rx_byte;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                sum_next = sum_reg + rx_byte;
                if (capture) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_DATA;
                    res.data_value     = rx_byte;
                    res.data_position  = count_reg[3:0];
                    count_next         = count_reg + 5'd1;
                end
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM: begin
                res_valid             = 1'b1;
                res.kind              = KIND_FRAME;
                res.received_checksum = rx_byte;
                res.expected_checksum = expect_csum;
                res.frame_status      = status;
                res.ack_request       = (status == ST_OK);
                phase_next = PH_WAIT;
                trunc_next = 1'b0;
                count_next = '0;
                sum_next   = '0;
            end
            default: begin
                // Drop the frame on a phase code without meaning
                phase_next = PH_WAIT;
                trunc_next = 1'b0;
                count_next = '0;
                sum_next   = '0;
            end
        endcase
    end

    // Advance state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT;
            command_reg <= '0;
            length_reg  <= '0;
            left_reg    <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            trunc_reg   <= 1'b0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            trunc_reg   <= trunc_next;
        end
    end

    // An acknowledge only comes with an OK frame report
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.ack_request) |->
            (res.kind == KIND_FRAME && res.frame_status == ST_OK))
        else $error("ack requested without OK frame");

    // A frame report closes the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_valid && res.kind == KIND_FRAME) |=>
            (phase_reg == PH_WAIT && count_reg == 5'd0 && sum_reg == 8'd0))
        else $error("frame not closed after report");

    // Captured positions stay within the buffer depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_DATA) |-> ({3'b000, count_reg} < DEPTH_B))
        else $error("data capture beyond buffer depth");

    // A truncated frame never reports OK
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_FRAME && trunc_reg) |-> (res.frame_status == ST_TRUNC))
        else $error("truncated frame not reported as TRUNC");

endmodule
